// ===== rtl/simplex_product_staircase_cells_defines.svh =====
// Assertion macros used by the port-level checker file
`ifndef SIMPLEX_PRODUCT_STAIRCASE_CELLS_DEFINES_SVH
`define SIMPLEX_PRODUCT_STAIRCASE_CELLS_DEFINES_SVH

// Check that cons holds whenever ante holds
`define SPSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Check that cons holds in the cycle after ante
`define SPSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== rtl/spsc_pkg.sv =====
// Package: shared types, constants and path functions
package spsc_pkg;

	localparam int ID_W   = 16;
	localparam int CNT_W  = 17;
	localparam int PID_W  = 32;
	localparam int NUM_ID = 4;
	localparam int NUM_V  = 7;
	localparam int PAT_W  = 6;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic       load;
		logic       mul_en;
		logic [1:0] mul_idx;
		logic       emit;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic out_full;
	} stat_t;

	function automatic logic [2:0] ones7(input logic [6:0] x);
		logic [2:0] c;
		c = 3'd0;
		for (int b = 0; b < 7; b++) begin
			c = c + {2'b00, x[b]};
		end
		return c;
	endfunction

	// Next larger step pattern with the same number of left-steps
	function automatic logic [PAT_W-1:0] next_pattern(input logic [PAT_W-1:0] pat);
		logic [6:0] pw;
		logic [6:0] lowest;
		logic [6:0] ripple;
		logic [2:0] cnt;
		logic [2:0] shift;
		logic [6:0] fill;
		pw     = {1'b0, pat};
		lowest = pw & (~pw + 7'd1);
		ripple = pw + lowest;
		cnt    = ones7(ripple ^ pw);
		shift  = (cnt >= 3'd2) ? (cnt - 3'd2) : 3'd0;
		fill   = (7'd1 << shift) - 7'd1;
		return PAT_W'(ripple | fill);
	endfunction

endpackage

// ===== rtl/spsc_ctrl.sv =====
// Controller: sequences load, product precompute and cell transfers
module spsc_ctrl import spsc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  logic  out_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t     state_q, state_d;
	logic [1:0] cnt_q;
	logic       emit_ok;

	assign emit_ok = !stat.out_full || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= 2'd0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_MUL) begin
				cnt_q <= cnt_q + 2'd1;
			end else begin
				cnt_q <= 2'd0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_MUL;
			end
			ST_MUL: begin
				if (cnt_q == 2'd3) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (emit_ok && stat.last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		cmd.load    = 1'b0;
		cmd.mul_en  = 1'b0;
		cmd.mul_idx = cnt_q;
		cmd.emit    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_MUL: begin
				cmd.mul_en = 1'b1;
			end
			ST_EMIT: begin
				cmd.emit = emit_ok;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

// ===== rtl/spsc_dp.sv =====
// Datapath: held pair, row products, path walk and output register
module spsc_dp import spsc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	output stat_t            stat,
	input  logic             cfg_wr,
	input  logic [CNT_W-1:0] cfg_data,
	input  logic [ID_W-1:0]  left_id_0,
	input  logic [ID_W-1:0]  left_id_1,
	input  logic [ID_W-1:0]  left_id_2,
	input  logic [ID_W-1:0]  left_id_3,
	input  logic [ID_W-1:0]  right_id_0,
	input  logic [ID_W-1:0]  right_id_1,
	input  logic [ID_W-1:0]  right_id_2,
	input  logic [ID_W-1:0]  right_id_3,
	input  logic [1:0]       left_dim,
	input  logic [1:0]       right_dim,
	input  logic             out_ready,
	output logic             out_valid,
	output logic [PID_W-1:0] cell_v0,
	output logic [PID_W-1:0] cell_v1,
	output logic [PID_W-1:0] cell_v2,
	output logic [PID_W-1:0] cell_v3,
	output logic [PID_W-1:0] cell_v4,
	output logic [PID_W-1:0] cell_v5,
	output logic [PID_W-1:0] cell_v6,
	output logic [2:0]       cell_size,
	output logic             last_cell
);

	logic [CNT_W-1:0] nvc_q;
	logic [ID_W-1:0]  lid_q [NUM_ID];
	logic [ID_W-1:0]  rid_q [NUM_ID];
	logic [1:0]       p_q, q_q;
	logic [PAT_W-1:0] pat_q;
	logic [PID_W-1:0] lp_q [NUM_ID];
	logic             out_valid_q;
	logic [PID_W-1:0] cell_q [NUM_V];
	logic [2:0]       size_q;
	logic             last_q;

	logic [2:0]       n;
	logic [PAT_W-1:0] last_pat;
	logic [PID_W-1:0] vert [NUM_V];
	logic [ID_W+CNT_W-1:0] prod;

	assign n        = {1'b0, p_q} + {1'b0, q_q};
	assign last_pat = PAT_W'((7'd1 << p_q) - 7'd1) << q_q;
	assign prod     = lid_q[cmd.mul_idx] * nvc_q;

	assign stat.last     = (pat_q == last_pat);
	assign stat.out_full = out_valid_q;

	always_comb begin
		logic [1:0] ii;
		logic [1:0] jj;
		logic [2:0] bi;
		ii      = 2'd0;
		jj      = 2'd0;
		vert[0] = lp_q[0] + PID_W'(rid_q[0]);
		for (int s = 0; s < NUM_V - 1; s++) begin
			bi = n - 3'(s) - 3'd1;
			if (3'(s) < n) begin
				if (pat_q[bi]) ii = ii + 2'd1;
				else           jj = jj + 2'd1;
				vert[s+1] = lp_q[ii] + PID_W'(rid_q[jj]);
			end else begin
				vert[s+1] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nvc_q       <= CNT_W'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) nvc_q <= cfg_data;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lid_q[0] <= left_id_0;
			lid_q[1] <= left_id_1;
			lid_q[2] <= left_id_2;
			lid_q[3] <= left_id_3;
			rid_q[0] <= right_id_0;
			rid_q[1] <= right_id_1;
			rid_q[2] <= right_id_2;
			rid_q[3] <= right_id_3;
			p_q      <= left_dim;
			q_q      <= right_dim;
			pat_q    <= PAT_W'((7'd1 << left_dim) - 7'd1);
		end else if (cmd.emit) begin
			pat_q <= next_pattern(pat_q);
		end
		if (cmd.mul_en) begin
			lp_q[cmd.mul_idx] <= prod[PID_W-1:0];
		end
		if (cmd.emit) begin
			cell_q <= vert;
			size_q <= n + 3'd1;
			last_q <= stat.last;
		end
	end

	assign out_valid = out_valid_q;
	assign cell_v0   = cell_q[0];
	assign cell_v1   = cell_q[1];
	assign cell_v2   = cell_q[2];
	assign cell_v3   = cell_q[3];
	assign cell_v4   = cell_q[4];
	assign cell_v5   = cell_q[5];
	assign cell_v6   = cell_q[6];
	assign cell_size = size_q;
	assign last_cell = last_q;

endmodule

// ===== rtl/simplex_product_staircase_cells.sv =====
// Top level: staircase cells of a simplex product, controller plus datapath
// After the input transfer the controller fills the row products, then emits cells via the output register.
// Cells flow at one cell per cycle while out_ready is high; a new item is taken only after the last cell is emitted.
// The single shared 16x17 multiplier fills the four row products before cells flow.
// Reset: arst_n clears the controller, output valid and sets right_vertex_count to 1.
module simplex_product_staircase_cells import spsc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CNT_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [ID_W-1:0]  left_id_0,
	input  logic [ID_W-1:0]  left_id_1,
	input  logic [ID_W-1:0]  left_id_2,
	input  logic [ID_W-1:0]  left_id_3,
	input  logic [ID_W-1:0]  right_id_0,
	input  logic [ID_W-1:0]  right_id_1,
	input  logic [ID_W-1:0]  right_id_2,
	input  logic [ID_W-1:0]  right_id_3,
	input  logic [1:0]       left_dim,
	input  logic [1:0]       right_dim,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [PID_W-1:0] cell_v0,
	output logic [PID_W-1:0] cell_v1,
	output logic [PID_W-1:0] cell_v2,
	output logic [PID_W-1:0] cell_v3,
	output logic [PID_W-1:0] cell_v4,
	output logic [PID_W-1:0] cell_v5,
	output logic [PID_W-1:0] cell_v6,
	output logic [2:0]       cell_size,
	output logic             last_cell
);

	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	spsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	spsc_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.cfg_wr     (cfg_valid & cfg_ready),
		.cfg_data   (cfg_data),
		.left_id_0  (left_id_0),
		.left_id_1  (left_id_1),
		.left_id_2  (left_id_2),
		.left_id_3  (left_id_3),
		.right_id_0 (right_id_0),
		.right_id_1 (right_id_1),
		.right_id_2 (right_id_2),
		.right_id_3 (right_id_3),
		.left_dim   (left_dim),
		.right_dim  (right_dim),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.cell_v0    (cell_v0),
		.cell_v1    (cell_v1),
		.cell_v2    (cell_v2),
		.cell_v3    (cell_v3),
		.cell_v4    (cell_v4),
		.cell_v5    (cell_v5),
		.cell_v6    (cell_v6),
		.cell_size  (cell_size),
		.last_cell  (last_cell)
	);

endmodule

// ===== rtl/spsc_chk.sv =====
// Checker: port-level properties of the cell generator, bound to the top level
`include "simplex_product_staircase_cells_defines.svh"

module spsc_chk import spsc_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [PID_W-1:0] cell_v0,
	input logic [2:0]       cell_size,
	input logic             last_cell
);

	`SPSC_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(cell_v0) && $stable(cell_size) && $stable(last_cell))
	`SPSC_ASSERT_IMP(a_size_nonzero, clk, arst_n, out_valid, cell_size != 3'd0)
	`SPSC_ASSERT_IMP(a_point_last, clk, arst_n, out_valid && cell_size == 3'd1, last_cell)
	`SPSC_ASSERT_NXT(a_busy_after_in, clk, arst_n, in_valid && in_ready, !in_ready)

endmodule

bind simplex_product_staircase_cells spsc_chk u_spsc_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.cell_v0   (cell_v0),
	.cell_size (cell_size),
	.last_cell (last_cell)
);

// ===== sim/spsc_cell_checker.sv =====
// Checker: predicts the staircase cells of each accepted simplex pair and compares the block's cells
module spsc_cell_checker import spsc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  logic [CNT_W-1:0] cfg_data,
	input  logic             in_valid,
	input  logic             in_ready,
	input  logic [ID_W-1:0]  left_id_0,
	input  logic [ID_W-1:0]  left_id_1,
	input  logic [ID_W-1:0]  left_id_2,
	input  logic [ID_W-1:0]  left_id_3,
	input  logic [ID_W-1:0]  right_id_0,
	input  logic [ID_W-1:0]  right_id_1,
	input  logic [ID_W-1:0]  right_id_2,
	input  logic [ID_W-1:0]  right_id_3,
	input  logic [1:0]       left_dim,
	input  logic [1:0]       right_dim,
	input  logic             out_valid,
	input  logic             out_ready,
	input  logic [PID_W-1:0] cell_v0,
	input  logic [PID_W-1:0] cell_v1,
	input  logic [PID_W-1:0] cell_v2,
	input  logic [PID_W-1:0] cell_v3,
	input  logic [PID_W-1:0] cell_v4,
	input  logic [PID_W-1:0] cell_v5,
	input  logic [PID_W-1:0] cell_v6,
	input  logic [2:0]       cell_size,
	input  logic             last_cell,
	output int               cell_backlog,
	output int               mismatch_count
);

	localparam int PEND_DEPTH = 64;

	typedef struct packed {
		logic [NUM_V-1:0][PID_W-1:0] vert;
		logic [2:0]                  size;
		logic                        last;
	} cell_t;

	cell_t            pend_mem [PEND_DEPTH];
	int               wr_ptr;
	int               rd_ptr;
	logic [CNT_W-1:0] vertex_count;
	int               errs;

	function automatic logic [PID_W-1:0] product_id(input logic [ID_W-1:0] u,
			input logic [ID_W-1:0] v);
		logic [PID_W+CNT_W-1:0] wide;
		wide = u * vertex_count + v;
		return wide[PID_W-1:0];
	endfunction

	function automatic void add_pending(input cell_t c);
		pend_mem[wr_ptr % PEND_DEPTH] = c;
		wr_ptr++;
	endfunction

	function automatic void expand_staircase(input logic [NUM_ID-1:0][ID_W-1:0] lid,
			input logic [NUM_ID-1:0][ID_W-1:0] rid, input logic [1:0] p,
			input logic [1:0] q);
		int    n;
		int    i;
		int    j;
		cell_t c;
		cell_t prev;
		logic  have;
		n = p + q;
		have = 1'b0;
		prev = '0;
		for (int pat = 0; pat < (1 << n); pat++) begin
			if ($countones(pat) == int'(p)) begin
				c = '0;
				i = 0;
				j = 0;
				c.vert[0] = product_id(lid[0], rid[0]);
				for (int s = 0; s < n; s++) begin
					if (pat[n-1-s])
						i++;
					else
						j++;
					c.vert[s+1] = product_id(lid[i], rid[j]);
				end
				c.size = 3'(n + 1);
				if (have)
					add_pending(prev);
				prev = c;
				have = 1'b1;
			end
		end
		prev.last = 1'b1;
		add_pending(prev);
	endfunction

	task automatic check_cell();
		cell_t want;
		cell_t got;
		got.vert = {cell_v6, cell_v5, cell_v4, cell_v3, cell_v2, cell_v1, cell_v0};
		got.size = cell_size;
		got.last = last_cell;
		if (wr_ptr == rd_ptr) begin
			errs++;
			$display("%0t: cell with no pending prediction: v0=%h size=%0d last=%b",
				$time, got.vert[0], got.size, got.last);
		end else begin
			want = pend_mem[rd_ptr % PEND_DEPTH];
			rd_ptr++;
			for (int k = 0; k < NUM_V; k++) begin
				if (want.vert[k] !== got.vert[k]) begin
					errs++;
					$display("%0t: cell_v%0d expected %h actual %h",
						$time, k, want.vert[k], got.vert[k]);
				end
			end
			if (want.size !== got.size) begin
				errs++;
				$display("%0t: cell_size expected %0d actual %0d", $time, want.size, got.size);
			end
			if (want.last !== got.last) begin
				errs++;
				$display("%0t: last_cell expected %b actual %b", $time, want.last, got.last);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr = 0;
			rd_ptr = 0;
			vertex_count = 17'd1;
			errs = 0;
			cell_backlog <= 0;
			mismatch_count <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				vertex_count = cfg_data;
			if (out_valid && out_ready)
				check_cell();
			if (in_valid && in_ready)
				expand_staircase({left_id_3, left_id_2, left_id_1, left_id_0},
					{right_id_3, right_id_2, right_id_1, right_id_0}, left_dim, right_dim);
			cell_backlog <= wr_ptr - rd_ptr;
			mismatch_count <= errs;
		end
	end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top: drives simplex pairs and vertex counts into the staircase cell block
module tb_top;
	import spsc_pkg::*;

	localparam int DRAIN_CYCLES   = 30;
	localparam int HOLD_CYCLES    = 200;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int ITEMS_PER_PHASE = 31;

	logic             clk;
	logic             arst_n;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CNT_W-1:0] cfg_data;
	logic             in_valid;
	logic             in_ready;
	logic [ID_W-1:0]  left_id_0;
	logic [ID_W-1:0]  left_id_1;
	logic [ID_W-1:0]  left_id_2;
	logic [ID_W-1:0]  left_id_3;
	logic [ID_W-1:0]  right_id_0;
	logic [ID_W-1:0]  right_id_1;
	logic [ID_W-1:0]  right_id_2;
	logic [ID_W-1:0]  right_id_3;
	logic [1:0]       left_dim;
	logic [1:0]       right_dim;
	logic             out_valid;
	logic             out_ready;
	logic [PID_W-1:0] cell_v0;
	logic [PID_W-1:0] cell_v1;
	logic [PID_W-1:0] cell_v2;
	logic [PID_W-1:0] cell_v3;
	logic [PID_W-1:0] cell_v4;
	logic [PID_W-1:0] cell_v5;
	logic [PID_W-1:0] cell_v6;
	logic [2:0]       cell_size;
	logic             last_cell;
	int               cell_backlog;
	int               mismatch_count;

	logic no_idle;
	logic hold_request;
	int   quiet_cycles;

	simplex_product_staircase_cells dut (.*);

	spsc_cell_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic offer_pair(input logic [NUM_ID-1:0][ID_W-1:0] lid,
			input logic [NUM_ID-1:0][ID_W-1:0] rid, input logic [1:0] p,
			input logic [1:0] q);
		in_valid   <= 1'b1;
		left_id_0  <= lid[0];
		left_id_1  <= lid[1];
		left_id_2  <= lid[2];
		left_id_3  <= lid[3];
		right_id_0 <= rid[0];
		right_id_1 <= rid[1];
		right_id_2 <= rid[2];
		right_id_3 <= rid[3];
		left_dim   <= p;
		right_dim  <= q;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic pause_sender();
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (cell_backlog != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_vertex_count(input logic [CNT_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic make_ids(output logic [NUM_ID-1:0][ID_W-1:0] ids, input logic sorted);
		logic [ID_W-1:0] a[NUM_ID];
		logic [ID_W-1:0] t;
		int              hi;
		hi = $urandom_range(0, 1) ? 65535 : $urandom_range(3, 300);
		for (int k = 0; k < NUM_ID; k++)
			a[k] = ID_W'($urandom_range(0, hi));
		if (sorted) begin
			for (int x = 0; x < NUM_ID - 1; x++) begin
				for (int y = 0; y < NUM_ID - 1 - x; y++) begin
					if (a[y] > a[y+1]) begin
						t = a[y];
						a[y] = a[y+1];
						a[y+1] = t;
					end
				end
			end
		end
		for (int k = 0; k < NUM_ID; k++)
			ids[k] = a[k];
	endtask

	initial begin
		logic hold_done;
		hold_done = 1'b0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			int gap;
			if (hold_request && !hold_done) begin
				hold_done = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!no_idle && $urandom_range(0, 2) == 0) begin
				gap = idle_len();
				if (gap == 0)
					gap = 1;
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		logic [NUM_ID-1:0][ID_W-1:0] lid;
		logic [NUM_ID-1:0][ID_W-1:0] rid;
		logic [1:0]                  p;
		logic [1:0]                  q;
		logic [CNT_W-1:0]            vc;
		logic                        sorted;
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_data     = '0;
		in_valid     = 1'b0;
		left_id_0    = '0;
		left_id_1    = '0;
		left_id_2    = '0;
		left_id_3    = '0;
		right_id_0   = '0;
		right_id_1   = '0;
		right_id_2   = '0;
		right_id_3   = '0;
		left_dim     = '0;
		right_dim    = '0;
		no_idle      = 1'b0;
		hold_request = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int pi = 0; pi < 4; pi++) begin
			for (int qi = 0; qi < 4; qi++) begin
				for (int k = 0; k < NUM_ID; k++) begin
					lid[k] = ID_W'(10 * k + pi);
					rid[k] = ID_W'(100 + 7 * k + qi);
				end
				offer_pair(lid, rid, 2'(pi), 2'(qi));
				pause_sender();
			end
		end
		offer_pair('0, '0, 2'd3, 2'd3);
		pause_sender();
		offer_pair('1, '1, 2'd3, 2'd3);
		pause_sender();
		offer_pair({16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA},
			{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555}, 2'd2, 2'd3);
		pause_sender();
		offer_pair({16'd0, 16'd1, 16'd2, 16'd3}, {16'd5, 16'd40, 16'd9, 16'd1}, 2'd3, 2'd2);
		pause_sender();

		for (int ph = 0; ph < 6; ph++) begin
			wait_idle();
			case (ph)
				0: vc = 17'd65536;
				1: vc = 17'd0;
				2: vc = 17'h1FFFF;
				3: vc = CNT_W'($urandom_range(2, 65535));
				4: vc = CNT_W'($urandom_range(1, 64));
				default: vc = 17'd1;
			endcase
			write_vertex_count(vc);
			no_idle = (ph == 2 || ph == 3);
			if (ph == 2)
				hold_request = 1'b1;
			offer_pair('1, '1, 2'd3, 2'd3);
			pause_sender();
			offer_pair('0, '1, 2'd3, 2'd1);
			pause_sender();
			repeat (ITEMS_PER_PHASE) begin
				sorted = ($urandom_range(0, 9) < 8);
				make_ids(lid, sorted);
				make_ids(rid, sorted);
				p = 2'($urandom_range(0, 3));
				q = 2'($urandom_range(0, 3));
				offer_pair(lid, rid, p, q);
				pause_sender();
			end
		end
		no_idle = 1'b0;
		wait_idle();

		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
